@@ hw/rtl/ssq_pkg.sv @@
// Shared types and codes of the score stream sequencer.
// Used by the front parser, the request queue, the back executor and the top level.
package ssq_pkg;

  // Channel count of the player, and the width of the channel field on the result.
  localparam int CHANNELS = 4;
  localparam int CHAN_W   = 2;
  localparam logic [4:0] CHAN_LIMIT = 5'(CHANNELS);

  // Queue between the parser and the executor.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Input request kinds, carried on in_tuser.
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Parser phases.
  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_PITCH = 2'd1;
  localparam logic [1:0] PH_DLOW  = 2'd2;

  // Command nibbles of a control byte.
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_END      = 4'hF;

  // Result events, carried on out_tuser.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_NOTE_ON  = 3'd1;
  localparam logic [2:0] EV_NOTE_OFF = 3'd2;
  localparam logic [2:0] EV_DELAY    = 3'd3;
  localparam logic [2:0] EV_FINISHED = 3'd4;
  localparam logic [2:0] EV_UNKNOWN  = 3'd5;
  localparam logic [2:0] EV_NEED     = 3'd6;

  // Operations handed from the parser to the executor.
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_NOTE_ON  = 3'd1;
  localparam logic [2:0] OP_NOTE_OFF = 3'd2;
  localparam logic [2:0] OP_DELAY    = 3'd3;
  localparam logic [2:0] OP_FINISH   = 3'd4;
  localparam logic [2:0] OP_UNKNOWN  = 3'd5;
  localparam logic [2:0] OP_TICK     = 3'd6;
  localparam logic [2:0] OP_START    = 3'd7;

  typedef struct packed {
    logic [2:0]        op;
    logic [CHAN_W-1:0] chan;
    logic [7:0]        pitch;
    logic [14:0]       delay;
  } ssq_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ssq_qstat_t;

endpackage

@@ hw/rtl/ssq_front.sv @@
// Front parser: accepts requests and turns score bytes into executor operations.
// Depends on ssq_pkg; feeds ssq_fifo.
module ssq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_tuser,   // req_type
  input  logic [7:0]         in_tdata,   // score_byte
  input  ssq_pkg::ssq_qstat_t q_stat,
  output logic               push,
  output ssq_pkg::ssq_entry_t push_data
);
  import ssq_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [6:0]  dhi_r, dhi_nxt;
  logic [14:0] dword;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;
  assign dword     = {dhi_r, in_tdata};

  always_comb begin
    push_data = '0;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    dhi_nxt   = dhi_r;
    case (in_tuser)
      REQ_TICK: begin
        push_data.op = OP_TICK;
      end
      REQ_START: begin
        push_data.op = OP_START;
        phase_nxt    = PH_CMD;
      end
      REQ_BYTE: begin
        phase_nxt = PH_CMD;
        case (phase_r)
          PH_PITCH: begin
            // out-of-range channel still eats its pitch byte
            if ({1'b0, pend_r} < CHAN_LIMIT) begin
              push_data.op    = OP_NOTE_ON;
              push_data.chan  = pend_r[CHAN_W-1:0];
              push_data.pitch = in_tdata;
            end
          end
          PH_DLOW: begin
            // drop zero delays
            if (dword != 15'd0) begin
              push_data.op    = OP_DELAY;
              push_data.delay = dword;
            end
          end
          default: begin
            if (!in_tdata[7]) begin
              dhi_nxt   = in_tdata[6:0];
              phase_nxt = PH_DLOW;
            end else begin
              case (in_tdata[7:4])
                CMD_NOTE_ON: begin
                  pend_nxt  = in_tdata[3:0];
                  phase_nxt = PH_PITCH;
                end
                CMD_NOTE_OFF: begin
                  if ({1'b0, in_tdata[3:0]} < CHAN_LIMIT) begin
                    push_data.op   = OP_NOTE_OFF;
                    push_data.chan = in_tdata[CHAN_W-1:0];
                  end
                end
                CMD_END: begin
                  push_data.op = OP_FINISH;
                end
                default: begin
                  push_data.op = OP_UNKNOWN;
                end
              endcase
            end
          end
        endcase
      end
      default: begin
        push_data.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      pend_r  <= '0;
      dhi_r   <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      dhi_r   <= dhi_nxt;
    end
  end

endmodule

@@ hw/rtl/ssq_fifo.sv @@
// Short request queue between the front parser and the back executor.
// Depends on ssq_pkg for the entry type and depth constants.
module ssq_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ssq_pkg::ssq_entry_t push_data,
  input  logic                pop,
  output ssq_pkg::ssq_entry_t pop_data,
  output ssq_pkg::ssq_qstat_t q_stat
);
  import ssq_pkg::*;

  ssq_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/ssq_back.sv @@
// Back executor: applies queued operations to countdown, elapsed time and play flag,
// and holds each result in the output register. Depends on ssq_pkg.
module ssq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ssq_pkg::ssq_qstat_t q_stat,
  input  ssq_pkg::ssq_entry_t pop_data,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2:0]          out_tuser,
  output logic [63:0]         out_tdata
);
  import ssq_pkg::*;

  logic [15:0]       cd_r, cd_nxt;
  logic [31:0]       el_r, el_nxt;
  logic              play_r, play_nxt;
  logic              valid_r;
  logic [2:0]        ev_r, ev_nxt;
  logic [63:0]       data_r, data_nxt;
  logic [CHAN_W-1:0] chan;
  logic [7:0]        pitch;
  logic [14:0]       dly;

  assign pop        = !q_stat.empty && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = data_r;

  always_comb begin
    cd_nxt   = cd_r;
    el_nxt   = el_r;
    play_nxt = play_r;
    ev_nxt   = EV_NONE;
    chan     = '0;
    pitch    = '0;
    dly      = '0;
    case (pop_data.op)
      OP_TICK: begin
        if (cd_r != 16'd0) begin
          cd_nxt = cd_r - 16'd1;
          if (cd_r == 16'd1) begin
            ev_nxt = EV_NEED;
          end
        end
      end
      OP_START: begin
        el_nxt   = '0;
        play_nxt = 1'b1;
        cd_nxt   = 16'd1;
      end
      OP_DELAY: begin
        cd_nxt = {1'b0, pop_data.delay};
        el_nxt = el_r + {17'd0, pop_data.delay};
        ev_nxt = EV_DELAY;
        dly    = pop_data.delay;
      end
      OP_NOTE_ON: begin
        ev_nxt = EV_NOTE_ON;
        chan   = pop_data.chan;
        pitch  = pop_data.pitch;
      end
      OP_NOTE_OFF: begin
        ev_nxt = EV_NOTE_OFF;
        chan   = pop_data.chan;
      end
      OP_FINISH: begin
        play_nxt = 1'b0;
        ev_nxt   = EV_FINISHED;
      end
      OP_UNKNOWN: begin
        play_nxt = 1'b0;
        ev_nxt   = EV_UNKNOWN;
      end
      default: begin
        ev_nxt = EV_NONE;
      end
    endcase
    // chan [1:0], pitch [9:2], delay_ms [24:10], elapsed_ms [56:25], playing [57]
    data_nxt = {6'd0, play_nxt, el_nxt, dly, pitch, chan};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r   <= ev_nxt;
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r    <= '0;
      el_r    <= '0;
      play_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cd_r    <= cd_nxt;
        el_r    <= el_nxt;
        play_r  <= play_nxt;
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/score_stream_sequencer.sv @@
// Score stream sequencer: parses a music score byte stream into note and timing events.
// Input channel (in_*): one request per beat; in_tuser is the kind (score byte,
//   millisecond tick, start playback), in_tdata the score byte.
// Result channel (out_*): exactly one result per request, in order; out_tuser is the
//   event code, out_tdata holds channel, pitch, delay, elapsed time and playing flag.
// Throughput: one request per cycle, sustained while out_tready stays high. The parser
//   state advances with each byte and the executor updates countdown and elapsed time.
// Path from request to result: the parser writes the queue entry, and the executor
//   pops it and registers its result in the output register.
// A four-entry queue separates parser and executor; when the receiver stalls, the
//   output register holds its result, the queue fills, and in_tready drops only once
//   four more requests are waiting.
// Reset (rst_n low, synchronous): parser back to command phase, queue emptied,
//   countdown, elapsed time and playing flag cleared, no result pending.
// Depends on ssq_pkg, ssq_front, ssq_fifo and ssq_back.
module score_stream_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // req_type
  input  logic [7:0]  in_tdata,    // score_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,   // event_res
  output logic [63:0] out_tdata    // chan, pitch, delay_ms, elapsed_ms, playing, zero pad
);
  import ssq_pkg::*;

  ssq_qstat_t q_stat;
  ssq_entry_t push_data, pop_data;
  logic       push, pop;

  ssq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ssq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  ssq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  // an accepted request must land in the queue
  a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !q_stat.empty)
    else $error("accepted request missing from queue");

  // a delay event always carries a nonzero length, other events none
  a_delay_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == EV_DELAY) == (out_tdata[24:10] != 15'd0)))
    else $error("delay length does not match event");

  // end of score and unknown control both stop playback
  a_stop_clears_play: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == EV_FINISHED || out_tuser == EV_UNKNOWN))
      |-> !out_tdata[57])
    else $error("playing flag still set after stop");

  // queue never reports full and empty together
  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");
`endif

endmodule

@@ test/score_stream_sequencer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for score_stream_sequencer: directed and random score requests,
// predicted event by event and compared against every result on the out_* stream.
// Depends on ssq_pkg and the score_stream_sequencer RTL.
module score_stream_sequencer_tb;
  import ssq_pkg::*;

  localparam int RANDOM_REQUESTS = 1400;
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLDOFF_CYCLES  = 150;
  localparam int SETTLE_CYCLES   = 12;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       drain_first;
  } score_req_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [1:0]  chan;
    logic [7:0]  pitch;
    logic [14:0] delay;
    logic [31:0] elapsed;
    logic        playing;
  } player_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = REQ_BYTE;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [2:0]  out_tuser;
  logic [63:0] out_tdata;

  score_stream_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),    // req_type
    .in_tdata   (in_tdata),    // score_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),   // event_res
    .out_tdata  (out_tdata)    // chan, pitch, delay_ms, elapsed_ms, playing, zero pad
  );

  initial begin
    forever #5 clk = ~clk;
  end

  score_req_t    score_reqs[$];
  player_event_t expected_events[$];
  int            sent_count = 0;
  int            got_count = 0;
  int            mismatches = 0;

  // Player state as seen by the predictor
  logic [1:0]  prs_phase = PH_CMD;
  logic [3:0]  held_chan = 4'd0;
  logic [6:0]  held_delay_hi = 7'd0;
  logic [15:0] ms_left = 16'd0;
  logic [31:0] total_ms = 32'd0;
  logic        is_playing = 1'b0;

  function automatic player_event_t play_request(score_req_t r);
    player_event_t res;
    logic [14:0]   dly;
    res = '0;
    case (r.kind)
      REQ_TICK: begin
        if (ms_left != 16'd0) begin
          ms_left = ms_left - 16'd1;
          if (ms_left == 16'd0) res.ev = EV_NEED;
        end
      end
      REQ_START: begin
        total_ms   = 32'd0;
        is_playing = 1'b1;
        ms_left    = 16'd1;
        prs_phase  = PH_CMD;
      end
      REQ_BYTE: begin
        if (prs_phase == PH_PITCH) begin
          prs_phase = PH_CMD;
          if (held_chan < CHANNELS) begin
            res.ev    = EV_NOTE_ON;
            res.chan  = held_chan[CHAN_W-1:0];
            res.pitch = r.data;
          end
        end else if (prs_phase == PH_DLOW) begin
          prs_phase = PH_CMD;
          dly = {held_delay_hi, r.data};
          if (dly != 15'd0) begin
            ms_left   = {1'b0, dly};
            total_ms  = total_ms + {17'd0, dly};
            res.ev    = EV_DELAY;
            res.delay = dly;
          end
        end else begin
          prs_phase = PH_CMD;
          if (!r.data[7]) begin
            held_delay_hi = r.data[6:0];
            prs_phase     = PH_DLOW;
          end else begin
            case (r.data[7:4])
              CMD_NOTE_ON: begin
                held_chan = r.data[3:0];
                prs_phase = PH_PITCH;
              end
              CMD_NOTE_OFF: begin
                if (r.data[3:0] < CHANNELS) begin
                  res.ev   = EV_NOTE_OFF;
                  res.chan = r.data[CHAN_W-1:0];
                end
              end
              CMD_END: begin
                is_playing = 1'b0;
                res.ev     = EV_FINISHED;
              end
              default: begin
                is_playing = 1'b0;
                res.ev     = EV_UNKNOWN;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    res.elapsed = total_ms;
    res.playing = is_playing;
    return res;
  endfunction

  // Driver: bursts of requests separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser  <= REQ_BYTE;
      in_tdata  <= 8'h00;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_events.push_back(play_request(score_reqs.pop_front()));
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (score_reqs.size() != 0 &&
                     !(score_reqs[0].drain_first && got_count != sent_count)) begin
          in_tvalid <= 1'b1;
          in_tuser  <= score_reqs[0].kind;
          in_tdata  <= score_reqs[0].data;
          burst_left--;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall segments of random style, plus long hold-offs
  int seg_left = 0;
  int seg_mode = 0;
  int holdoff_left = 0;
  int holdoffs_done = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_tready   <= 1'b0;
    end else if (holdoffs_done < 2 && got_count >= 300 + 700 * holdoffs_done) begin
      holdoff_left  <= HOLDOFF_CYCLES;
      holdoffs_done <= holdoffs_done + 1;
      out_tready    <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        seg_mode = $urandom_range(0, 2);
      end
      seg_left--;
      case (seg_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: compare every result against the oldest prediction
  player_event_t seen, want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_count <= got_count + 1;
      seen.ev      = out_tuser;
      seen.chan    = out_tdata[1:0];
      seen.pitch   = out_tdata[9:2];
      seen.delay   = out_tdata[24:10];
      seen.elapsed = out_tdata[56:25];
      seen.playing = out_tdata[57];
      if (expected_events.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing expected: ev=%0d", $realtime, seen.ev);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (seen.ev != want.ev || seen.chan != want.chan || seen.pitch != want.pitch ||
            seen.delay != want.delay || seen.elapsed != want.elapsed ||
            seen.playing != want.playing) begin
          if (mismatches < 10) begin
            $write("%0t: mismatch exp ev=%0d ch=%0d p=%0d d=%0d el=%0d pl=%0d",
                   $realtime, want.ev, want.chan, want.pitch, want.delay, want.elapsed,
                   want.playing);
            $display(" | got ev=%0d ch=%0d p=%0d d=%0d el=%0d pl=%0d",
                     seen.ev, seen.chan, seen.pitch, seen.delay, seen.elapsed,
                     seen.playing);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_req(input logic [1:0] kind, input logic [7:0] data);
    score_req_t r;
    r.kind        = kind;
    r.data        = data;
    r.drain_first = 1'b0;
    score_reqs.push_back(r);
  endtask

  function automatic logic [3:0] pick_chan();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(CHANNELS, 15))
                                       : 4'($urandom_range(0, CHANNELS - 1));
  endfunction

  // One random sequence: mostly well-formed commands, some broken or noise
  task automatic add_random_sequence();
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      add_req(REQ_BYTE, {CMD_NOTE_ON, pick_chan()});
      add_req(REQ_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 34) begin
      add_req(REQ_BYTE, {CMD_NOTE_OFF, pick_chan()});
    end else if (pick < 56) begin
      if ($urandom_range(0, 3) != 0) begin
        add_req(REQ_BYTE, 8'h00);
        add_req(REQ_BYTE, 8'($urandom_range(0, 10)));
      end else begin
        add_req(REQ_BYTE, 8'($urandom_range(0, 127)));
        add_req(REQ_BYTE, 8'($urandom_range(0, 255)));
      end
    end else if (pick < 78) begin
      n = $urandom_range(1, 12);
      repeat (n) add_req(REQ_TICK, 8'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      add_req(REQ_START, 8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      add_req(REQ_BYTE, {CMD_END, 4'($urandom_range(0, 15))});
    end else if (pick < 89) begin
      b = 8'($urandom_range(128, 255));
      while (b[7:4] == CMD_NOTE_ON || b[7:4] == CMD_NOTE_OFF || b[7:4] == CMD_END)
        b = 8'($urandom_range(128, 255));
      add_req(REQ_BYTE, b);
    end else if (pick < 95) begin
      // interrupt a two-byte command halfway
      if ($urandom_range(0, 1) == 0)
        add_req(REQ_BYTE, {CMD_NOTE_ON, pick_chan()});
      else
        add_req(REQ_BYTE, 8'($urandom_range(0, 127)));
      add_req(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
    end else begin
      add_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int next_drain;
    next_drain = 25 + 450;
    // directed: idle tick, unused request, start, notes, delays, end, unknown
    add_req(REQ_TICK, 8'h00);
    add_req(2'd3, 8'hFF);
    add_req(REQ_START, 8'h00);
    add_req(REQ_TICK, 8'h00);
    add_req(REQ_BYTE, {CMD_NOTE_ON, 4'd0});
    add_req(REQ_BYTE, 8'h00);
    add_req(REQ_BYTE, {CMD_NOTE_ON, 4'd3});
    add_req(REQ_BYTE, 8'hFF);
    add_req(REQ_BYTE, {CMD_NOTE_ON, 4'd15});
    add_req(REQ_BYTE, 8'h55);
    add_req(REQ_BYTE, {CMD_NOTE_OFF, 4'd0});
    add_req(REQ_BYTE, {CMD_NOTE_OFF, 4'd3});
    add_req(REQ_BYTE, {CMD_NOTE_OFF, 4'd4});
    add_req(REQ_BYTE, 8'h00);
    add_req(REQ_BYTE, 8'h00);
    add_req(REQ_BYTE, 8'h7F);
    add_req(REQ_BYTE, 8'hFF);
    add_req(REQ_BYTE, 8'h00);
    add_req(REQ_BYTE, 8'h02);
    add_req(REQ_TICK, 8'h00);
    add_req(REQ_TICK, 8'h00);
    add_req(REQ_BYTE, {CMD_NOTE_ON, 4'd1});
    add_req(REQ_START, 8'hAA);
    add_req(REQ_BYTE, 8'hA5);
    add_req(REQ_BYTE, {CMD_END, 4'd3});

    while (score_reqs.size() < 25 + RANDOM_REQUESTS) begin
      add_random_sequence();
      // let everything drain at the end of the directed part and now and then
      if (score_reqs.size() >= next_drain) begin
        score_reqs[score_reqs.size() - 1].drain_first = 1'b1;
        next_drain += 450;
      end
    end
    score_reqs[25].drain_first = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (score_reqs.size() != 0 || in_tvalid || got_count < sent_count)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_events.size() != 0) begin
      $display("%0d predicted results never arrived", expected_events.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
